/* rtl/swm_pkg.sv */
// Shared types and constants for the sliding window median unit.
`default_nettype none
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT   = 64;
   localparam int SAMPLE_WIDTH_DEFAULT = 32;
   localparam int CSR_WIDTH            = 7;
   localparam logic [CSR_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

   typedef struct packed {
      logic live;
      logic le;
      logic rge;
      logic del;
   } swm_flags_type;

   typedef enum logic {
      SWM_IDLE,
      SWM_EMIT
   } swm_state_type;

endpackage
`default_nettype wire

/* rtl/swm_cell.sv */
// One cell of the sorted window chain: holds a sample and its age.
`default_nettype none
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int AGE_W        = 6,
   parameter bit FIRST        = 1'b0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           clear,
   input  wire logic                           step,
   input  wire logic                           start,
   input  wire logic                           full,
   input  wire logic [AGE_W-1:0]               oldest_age,
   input  wire logic signed [SAMPLE_WIDTH-1:0] new_value,
   input  wire logic signed [SAMPLE_WIDTH-1:0] old_value,
   input  wire swm_flags_type                  left_flags,
   input  wire logic signed [SAMPLE_WIDTH-1:0] left_value,
   input  wire logic [AGE_W-1:0]               left_age,
   input  wire swm_flags_type                  right_flags,
   input  wire logic signed [SAMPLE_WIDTH-1:0] right_value,
   input  wire logic [AGE_W-1:0]               right_age,
   output swm_flags_type                       flags,
   output logic signed [SAMPLE_WIDTH-1:0]      value,
   output logic [AGE_W-1:0]                    age,
   output logic                                valid
);

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic [AGE_W-1:0]               age_ff, age_in;
   logic                           valid_eff;
   logic                           x_le;
   logic signed [SAMPLE_WIDTH-1:0] x_value;
   logic [AGE_W-1:0]               x_age;
   logic                           y_le, y_live;
   logic signed [SAMPLE_WIDTH-1:0] y_value;
   logic [AGE_W-1:0]               y_age;

   // local view: removal of the oldest entry and placement against the new sample
   always_comb begin
      valid_eff  = valid_ff && !start;
      flags.del  = full && valid_eff && (age_ff == oldest_age);
      flags.live = valid_eff && !flags.del;
      flags.le   = flags.live && (value_ff <= new_value);
      flags.rge  = !full || (flags.live && (value_ff < old_value));
   end

   // X: entry j after removal, Y: entry j-1 after removal
   always_comb begin
      x_le    = flags.rge ? flags.le : right_flags.le;
      x_value = flags.rge ? value_ff : right_value;
      x_age   = flags.rge ? age_ff   : right_age;
      y_le    = left_flags.rge ? left_flags.le   : flags.le;
      y_live  = left_flags.rge ? left_flags.live : flags.live;
      y_value = left_flags.rge ? left_value      : value_ff;
      y_age   = left_flags.rge ? left_age        : age_ff;
      priority if (x_le) begin
         valid_in = 1'b1;
         value_in = x_value;
         age_in   = x_age + 1'b1;
      end else if (FIRST || y_le) begin
         valid_in = 1'b1;
         value_in = new_value;
         age_in   = '0;
      end else begin
         valid_in = y_live;
         value_in = y_value;
         age_in   = y_age + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

/* rtl/swm_pick.sv */
// Median selection from the sorted chain: sum of the two middle entries.
`default_nettype none
module swm_pick
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int AGE_W        = 6
) (
   input  wire logic signed [SAMPLE_WIDTH-1:0] values [WINDOW_MAX],
   input  wire logic [AGE_W-1:0]               lo_idx,
   input  wire logic [AGE_W-1:0]               hi_idx,
   output logic signed [SAMPLE_WIDTH:0]        median_x2
);

   logic [SAMPLE_WIDTH-1:0] lo_bits, hi_bits;

   always_comb begin
      lo_bits = '0;
      hi_bits = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (lo_idx == AGE_W'(i)) lo_bits = lo_bits | values[i];
         if (hi_idx == AGE_W'(i)) hi_bits = hi_bits | values[i];
      end
      median_x2 = $signed({lo_bits[SAMPLE_WIDTH-1], lo_bits})
                + $signed({hi_bits[SAMPLE_WIDTH-1], hi_bits});
   end

endmodule
`default_nettype wire

/* rtl/sliding_window_median_unit.sv */
// Top level of the sliding window median unit.
// Usage:
//   Requests arrive on req_* (tdata = sample, tuser = start flag). A request with
//   the start flag set empties the window before its sample enters.
//   Results leave on rsp_*: tdata = twice the window median (one fractional bit).
//   No result is given until the window holds window_size samples; after that
//   every request gives exactly one result until the window is emptied again.
//   csr_we/csr_wdata set window_size (0 acts as 1, values above WINDOW_MAX
//   saturate) and empty the window; write only while the unit is idle.
// Timing:
//   The sorted cell chain takes the sample in the cycle of acceptance; the
//   median is picked from the chain and registered in the EMIT state, once
//   the output register is free; no request is taken in the EMIT state.
//   rsp_tvalid rises when the median is registered.
//   The output register holds a result while rsp_tready is low; the unit
//   stalls only when a second result is ready before the first is taken.
// Reset: window_size returns to 3, the window is empty, no result pending.
`default_nettype none
module sliding_window_median_unit
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   localparam int IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int OUT_W = ((SAMPLE_WIDTH + 8) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [IN_W-1:0]      req_tdata,   // [SAMPLE_WIDTH-1:0] sample
   input  wire logic                 req_tuser,   // [0] start_req
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [OUT_W-1:0]          rsp_tdata,   // [SAMPLE_WIDTH:0] median_x2
   input  wire logic                 csr_we,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata
);

   localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int K_W   = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (K_W > CSR_WIDTH) ? K_W : CSR_WIDTH;

   logic [CSR_WIDTH-1:0]    wsize_ff;
   logic [K_W-1:0]          fill_ff, fill_in;
   swm_state_type           state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH:0]   rsp_data_ff;
   logic                    load_rsp;

   logic [CMP_W-1:0]        wsize_ext;
   logic [K_W-1:0]          k_size, fill_eff, k_minus1, k_half;
   logic                    accept, start, full;
   logic signed [SAMPLE_WIDTH-1:0] new_value, old_value;
   logic signed [SAMPLE_WIDTH:0]   median_x2;

   swm_flags_type                  cell_flags [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
   logic [AGE_W-1:0]               cell_age   [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]          cell_valid;

   assign accept    = req_tvalid && req_tready;
   assign start     = req_tuser;
   assign new_value = $signed(req_tdata[SAMPLE_WIDTH-1:0]);

   always_comb begin
      wsize_ext = CMP_W'(wsize_ff);
      priority if (wsize_ext == '0) begin
         k_size = K_W'(1);
      end else if (wsize_ext > CMP_W'(WINDOW_MAX)) begin
         k_size = K_W'(WINDOW_MAX);
      end else begin
         k_size = K_W'(wsize_ext);
      end
      k_minus1 = k_size - 1'b1;
      k_half   = k_size >> 1;
      fill_eff = start ? '0 : fill_ff;
      full     = (fill_eff == k_size);
      fill_in  = full ? fill_eff : fill_eff + 1'b1;
   end

   always_comb begin
      old_value = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (cell_flags[i].del) old_value = old_value | cell_value[i];
      end
   end

   for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
      swm_flags_type                  l_flags, r_flags;
      logic signed [SAMPLE_WIDTH-1:0] l_value, r_value;
      logic [AGE_W-1:0]               l_age, r_age;

      if (g == 0) begin : g_left_edge
         assign l_flags = '0;
         assign l_value = '0;
         assign l_age   = '0;
      end else begin : g_left
         assign l_flags = cell_flags[g-1];
         assign l_value = cell_value[g-1];
         assign l_age   = cell_age[g-1];
      end

      if (g == WINDOW_MAX - 1) begin : g_right_edge
         assign r_flags = '0;
         assign r_value = '0;
         assign r_age   = '0;
      end else begin : g_right
         assign r_flags = cell_flags[g+1];
         assign r_value = cell_value[g+1];
         assign r_age   = cell_age[g+1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .AGE_W        (AGE_W),
         .FIRST        (g == 0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .clear       (csr_we),
         .step        (accept),
         .start       (start),
         .full        (full),
         .oldest_age  (k_minus1[AGE_W-1:0]),
         .new_value   (new_value),
         .old_value   (old_value),
         .left_flags  (l_flags),
         .left_value  (l_value),
         .left_age    (l_age),
         .right_flags (r_flags),
         .right_value (r_value),
         .right_age   (r_age),
         .flags       (cell_flags[g]),
         .value       (cell_value[g]),
         .age         (cell_age[g]),
         .valid       (cell_valid[g])
      );
   end

   swm_pick #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_W        (AGE_W)
   ) u_pick (
      .values    (cell_value),
      .lo_idx    (AGE_W'(k_minus1 >> 1)),
      .hi_idx    (k_half[AGE_W-1:0]),
      .median_x2 (median_x2)
   );

   always_comb begin
      state_in     = state_ff;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      unique case (state_ff)
         SWM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (fill_in == k_size)) begin
               state_in = SWM_EMIT;
            end
         end
         SWM_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = SWM_IDLE;
            end
         end
         default: state_in = SWM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SWM_IDLE;
         rsp_valid_ff <= 1'b0;
         wsize_ff     <= WINDOW_SIZE_RESET;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            wsize_ff <= csr_wdata;
            fill_ff  <= '0;
         end else if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= median_x2;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_data_ff);

`ifndef SYNTHESIS
   a_fill_matches_chain: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(fill_ff))
      else $error("chain occupancy differs from fill count");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= k_size)
      else $error("fill count beyond window size");

   a_emit_needs_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == SWM_EMIT |-> fill_ff == k_size)
      else $error("median requested from a window that is not full");

   a_start_refills: assert property (@(posedge clock) disable iff (reset)
      accept && start && !csr_we |=> fill_ff == K_W'(1))
      else $error("start request did not empty the window");
`endif

endmodule
`default_nettype wire
